// ----- hdl/tiny_isa_execute_unit_top_macros.svh -----
// ----------------------------------------------------------------------------
// Tiny ISA execute unit - assertion macros
// Shared concurrent assertion forms for the execute unit.
// ----------------------------------------------------------------------------
`ifndef TINY_ISA_EXECUTE_UNIT_TOP_MACROS_SVH
`define TINY_ISA_EXECUTE_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define TIE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tie_pkg.sv -----
// ----------------------------------------------------------------------------
// Tiny ISA execute unit - package
// Opcodes, fault codes, conditions and controller/datapath structs.
// ----------------------------------------------------------------------------
package tie_pkg;

  localparam int REG_COUNT = 8;

  localparam logic [3:0] OP_MOV = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_MUL = 4'd3;
  localparam logic [3:0] OP_DIV = 4'd4;
  localparam logic [3:0] OP_MOD = 4'd5;
  localparam logic [3:0] OP_CMP = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_LD  = 4'd8;
  localparam logic [3:0] OP_ST  = 4'd9;

  localparam logic [2:0] FLT_NONE   = 3'd0;
  localparam logic [2:0] FLT_OPCODE = 3'd1;
  localparam logic [2:0] FLT_DIV0   = 3'd2;
  localparam logic [2:0] FLT_REG    = 3'd3;
  localparam logic [2:0] FLT_ADDR   = 3'd4;
  localparam logic [2:0] FLT_TARGET = 3'd5;

  localparam logic [2:0] CC_EQ = 3'd0;
  localparam logic [2:0] CC_NE = 3'd1;
  localparam logic [2:0] CC_LT = 3'd2;
  localparam logic [2:0] CC_GT = 3'd3;
  localparam logic [2:0] CC_LE = 3'd4;
  localparam logic [2:0] CC_GE = 3'd5;
  localparam logic [2:0] CC_AL = 3'd6;
  localparam logic [2:0] CC_NV = 3'd7;

  typedef struct packed {
    logic accept;
    logic rd_a;
    logic rd_b;
    logic opnd;
    logic div_step;
    logic mem_rd;
    logic finish;
  } tie_cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_mem;
    logic div_last;
    logic out_free;
  } tie_st_t;

endpackage

// ----- hdl/tie_if.sv -----
// ----------------------------------------------------------------------------
// Tiny ISA execute unit - channel interfaces
// Valid/ready channels for instruction beats and result beats.
// ----------------------------------------------------------------------------
interface tie_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface tie_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        next_pc;
  logic               halted;
  logic               reg_written;
  logic [2:0]         reg_index;
  logic signed [31:0] reg_value;
  logic               mem_written;
  logic [7:0]         mem_address;
  logic signed [7:0]  mem_value;
  logic               compare_zero;
  logic               compare_negative;
  logic [2:0]         fault;

  modport source (output valid, output next_pc, output halted, output reg_written,
                  output reg_index, output reg_value, output mem_written,
                  output mem_address, output mem_value, output compare_zero,
                  output compare_negative, output fault, input ready);
  modport sink   (input valid, input next_pc, input halted, input reg_written,
                  input reg_index, input reg_value, input mem_written,
                  input mem_address, input mem_value, input compare_zero,
                  input compare_negative, input fault, output ready);
endinterface

// ----- hdl/tie_ctrl.sv -----
// ----------------------------------------------------------------------------
// Tiny ISA execute unit - controller
// Sequences register reads, operand capture, division, memory read, commit.
// ----------------------------------------------------------------------------
module tie_ctrl import tie_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tie_st_t  st,
  output tie_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDA   = 7'b0000010,
    S_RDB   = 7'b0000100,
    S_OPND  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_MEMRD = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_RDA;
      S_RDA:   state_nxt = S_RDB;
      S_RDB:   state_nxt = S_OPND;
      S_OPND: begin
        priority if (st.need_div) state_nxt = S_DIV;
        else if (st.need_mem)     state_nxt = S_MEMRD;
        else                      state_nxt = S_FIN;
      end
      S_DIV:   if (st.div_last) state_nxt = S_FIN;
      S_MEMRD: state_nxt = S_FIN;
      S_FIN:   if (st.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready     = (state_r == S_IDLE);
  assign cmd.accept   = (state_r == S_IDLE) && in_valid;
  assign cmd.rd_a     = (state_r == S_RDA);
  assign cmd.rd_b     = (state_r == S_RDB);
  assign cmd.opnd     = (state_r == S_OPND);
  assign cmd.div_step = (state_r == S_DIV);
  assign cmd.mem_rd   = (state_r == S_MEMRD);
  assign cmd.finish   = (state_r == S_FIN) && st.out_free;

endmodule

// ----- hdl/tie_dp.sv -----
// ----------------------------------------------------------------------------
// Tiny ISA execute unit - datapath
// Register file, data memory, flags, pc, divider and result register.
// ----------------------------------------------------------------------------
module tie_dp import tie_pkg::*; #(
  parameter int DATA_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic [15:0]        instruction,
  input  tie_cmd_t           cmd,
  output tie_st_t            st,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [15:0]        next_pc,
  output logic               halted,
  output logic               reg_written,
  output logic [2:0]         reg_index,
  output logic signed [31:0] reg_value,
  output logic               mem_written,
  output logic [7:0]         mem_address,
  output logic signed [7:0]  mem_value,
  output logic               compare_zero,
  output logic               compare_negative,
  output logic [2:0]         fault
);

  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam logic [31:0] DEPTH32 = 32'(DATA_DEPTH);

  logic [15:0] ins_r, plen_r, pc_r;
  logic [31:0] rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;
  logic [31:0] rf_q_r, a_r, b_r;
  logic [7:0]  dmem [DATA_DEPTH];
  logic [DATA_DEPTH-1:0] dm_vld_r;
  logic [7:0]  mrd_r;
  logic        fz_r, fn_r;
  logic [31:0] quot_r, rem_r;
  logic [4:0]  cnt_r;
  logic        out_valid_r;

  logic [3:0]  op;
  logic        imm, is_arith, bad_reg;
  logic [2:0]  rsel, rf_addr;
  logic [31:0] immv, b_val, ua, div_sub;
  logic [32:0] div_t;

  assign op       = ins_r[15:12];
  assign imm      = ins_r[11];
  assign rsel     = ins_r[10:8];
  assign is_arith = (op >= OP_ADD) && (op <= OP_MOD);
  assign bad_reg  = !imm && (op <= OP_ST) &&
                    (is_arith ? (ins_r[4:3] != 2'b0) : (ins_r[7:3] != 5'b0));

  always_comb begin
    priority if (is_arith)
      immv = ins_r[4] ? (32'd0 - {28'd0, ins_r[3:0]}) : {28'd0, ins_r[3:0]};
    else if (op >= OP_LD)
      immv = {24'd0, ins_r[7:0]};
    else
      immv = ins_r[7] ? (32'd0 - {25'd0, ins_r[6:0]}) : {25'd0, ins_r[6:0]};
  end

  assign b_val   = imm ? immv : rf_q_r;
  assign rf_addr = cmd.rd_b ? ins_r[2:0] : (is_arith ? ins_r[7:5] : rsel);

  assign st.need_div = ((op == OP_DIV) || (op == OP_MOD)) && !bad_reg && (b_val != 32'd0);
  assign st.need_mem = (op == OP_LD) && !bad_reg && !b_val[31] && (b_val < DEPTH32);
  assign st.div_last = (cnt_r == 5'd31);
  assign st.out_free = !out_valid_r || out_ready;

  // divider operand magnitudes
  assign ua      = a_r[31] ? (32'd0 - a_r) : a_r;
  assign div_t   = {rem_r, quot_r[31]};
  assign div_sub = b_r[31] ? (32'd0 - b_r) : b_r;

  // ---------------------------------------------------------------- execute
  logic        halt_in, take, commit, rw, mw;
  logic [2:0]  flt;
  logic [16:0] npc;
  logic [31:0] rv, mul, qf, rf, tgt;
  logic        fz_nxt, fn_nxt;

  assign halt_in = (pc_r >= plen_r);
  assign mul     = 32'(a_r * b_r);
  assign qf      = (a_r[31] ^ b_r[31]) ? (32'd0 - quot_r) : quot_r;
  assign rf      = a_r[31] ? (32'd0 - rem_r) : rem_r;
  assign tgt     = b_r - 32'd1;

  always_comb begin
    unique case (rsel)
      CC_EQ:   take = fz_r;
      CC_NE:   take = !fz_r;
      CC_LT:   take = fn_r;
      CC_GT:   take = !fz_r && !fn_r;
      CC_LE:   take = fz_r || fn_r;
      CC_GE:   take = !fn_r;
      CC_AL:   take = 1'b1;
      CC_NV:   take = 1'b0;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    flt = FLT_NONE;
    npc = {1'b0, pc_r} + 17'd1;
    rv  = 32'd0;
    rw  = 1'b0;
    mw  = 1'b0;
    unique case (op)
      OP_MOV: begin rv = b_r; rw = 1'b1; end
      OP_ADD: begin rv = a_r + b_r; rw = 1'b1; end
      OP_SUB: begin rv = a_r - b_r; rw = 1'b1; end
      OP_MUL: begin rv = mul; rw = 1'b1; end
      OP_DIV: begin rv = qf; rw = 1'b1; end
      OP_MOD: begin rv = rf; rw = 1'b1; end
      OP_CMP: ;
      OP_JMP: begin
        if (take) begin
          if (b_r[31] || (b_r == 32'd0)) flt = FLT_TARGET;
          else if (tgt > 32'h0000_FFFF)  npc = 17'h0FFFF;
          else                            npc = {1'b0, tgt[15:0]};
        end
      end
      OP_LD: begin
        rv = {{24{mrd_r[7]}}, mrd_r};
        rw = 1'b1;
        if (b_r[31] || (b_r >= DEPTH32)) flt = FLT_ADDR;
      end
      OP_ST: begin
        mw = 1'b1;
        if (b_r[31] || (b_r >= DEPTH32)) flt = FLT_ADDR;
      end
      default: flt = FLT_OPCODE;
    endcase
    priority if (op > OP_ST)                                     flt = FLT_OPCODE;
    else if (bad_reg)                                            flt = FLT_REG;
    else if (((op == OP_DIV) || (op == OP_MOD)) && (b_r == 32'd0)) flt = FLT_DIV0;
    else                                                         flt = flt;
    if (halt_in || (flt != FLT_NONE)) begin
      npc = {1'b0, pc_r};
      rw  = 1'b0;
      mw  = 1'b0;
    end
    if (halt_in) flt = FLT_NONE;
  end

  assign commit = cmd.finish && !halt_in && (flt == FLT_NONE);
  assign fz_nxt = (commit && (op == OP_CMP)) ? (a_r == b_r) : fz_r;
  assign fn_nxt = (commit && (op == OP_CMP)) ? ($signed(a_r) < $signed(b_r)) : fn_r;

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= 16'd0;
      pc_r        <= 16'd0;
      fz_r        <= 1'b1;
      fn_r        <= 1'b0;
      rf_vld_r    <= '0;
      dm_vld_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= 5'd0;
    end else begin
      if (cfg_wr_en) plen_r <= cfg_wr_data;
      if (commit) pc_r <= npc[15:0];
      fz_r <= fz_nxt;
      fn_r <= fn_nxt;
      if (commit && rw) rf_vld_r[rsel] <= 1'b1;
      if (commit && mw) dm_vld_r[b_r[AW-1:0]] <= 1'b1;
      if (cmd.opnd) cnt_r <= 5'd0;
      else if (cmd.div_step) cnt_r <= cnt_r + 5'd1;
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) ins_r <= instruction;
    if (cmd.rd_a || cmd.rd_b) rf_q_r <= rf_vld_r[rf_addr] ? rf_mem[rf_addr] : 32'd0;
    if (cmd.rd_b) a_r <= rf_q_r;
    if (cmd.opnd) begin
      b_r    <= b_val;
      quot_r <= ua;
      rem_r  <= 32'd0;
    end else if (cmd.div_step) begin
      if (div_t >= {1'b0, div_sub}) begin
        rem_r  <= 32'(div_t - {1'b0, div_sub});
        quot_r <= {quot_r[30:0], 1'b1};
      end else begin
        rem_r  <= div_t[31:0];
        quot_r <= {quot_r[30:0], 1'b0};
      end
    end
    if (cmd.mem_rd) mrd_r <= dm_vld_r[b_r[AW-1:0]] ? dmem[b_r[AW-1:0]] : 8'd0;
    if (commit && rw) rf_mem[rsel] <= rv;
    if (commit && mw) dmem[b_r[AW-1:0]] <= a_r[7:0];
    if (cmd.finish) begin
      next_pc          <= npc[15:0];
      halted           <= halt_in || (npc >= {1'b0, plen_r});
      reg_written      <= rw;
      reg_index        <= rw ? rsel : 3'd0;
      reg_value        <= rw ? rv : 32'd0;
      mem_written      <= mw;
      mem_address      <= mw ? b_r[7:0] : 8'd0;
      mem_value        <= mw ? a_r[7:0] : 8'd0;
      compare_zero     <= fz_nxt;
      compare_negative <= fn_nxt;
      fault            <= flt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/tiny_isa_execute_unit_top.sv -----
// Steps: accept, read A, read B, capture operands, then a memory read for an
// in-range load or a 32-step restoring divider for div and mod, then finish.
// Throughput: one instruction at a time; next beat taken the cycle after the
// result registers load; finish waits while the output is stalled.
// Reset (rst_n low, synchronous): registers, data memory, pc read as zero,
// zero flag set; program_length zero, so the unit starts halted.
// ----------------------------------------------------------------------------
// Tiny ISA execute unit - top level
// Controller and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
`include "tiny_isa_execute_unit_top_macros.svh"

module tiny_isa_execute_unit_top import tie_pkg::*; #(
  parameter int DATA_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  tie_in_if.sink      in_ch,
  tie_out_if.source   out_ch
);

  tie_cmd_t cmd;
  tie_st_t  st;

  tie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  tie_dp #(.DATA_DEPTH(DATA_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .instruction      (in_ch.instruction),
    .cmd              (cmd),
    .st               (st),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .next_pc          (out_ch.next_pc),
    .halted           (out_ch.halted),
    .reg_written      (out_ch.reg_written),
    .reg_index        (out_ch.reg_index),
    .reg_value        (out_ch.reg_value),
    .mem_written      (out_ch.mem_written),
    .mem_address      (out_ch.mem_address),
    .mem_value        (out_ch.mem_value),
    .compare_zero     (out_ch.compare_zero),
    .compare_negative (out_ch.compare_negative),
    .fault            (out_ch.fault)
  );

  `TIE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "accepted while busy")
  `TIE_ASSERT_NEXT(a_finish_shows, clk, rst_n, cmd.finish, out_ch.valid, "result beat not presented")
  `TIE_ASSERT_SAME(a_fault_no_write, clk, rst_n, out_ch.valid && (out_ch.fault != FLT_NONE), !out_ch.reg_written && !out_ch.mem_written, "write on fault")

endmodule
